>>> hw/rtl/ppso_pkg.sv
// ----------------------------------------------------------------------------
// ppso_pkg
// shared constants for the polygon point / segment overlap block
// ----------------------------------------------------------------------------
`default_nettype none
package ppso_pkg;
  localparam int MaxVertices = 64;
  localparam int CoordWidth  = 32;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = 7;
  localparam int DiffW       = CoordWidth + 2;
  localparam int ProdW       = 2 * DiffW;
  localparam int WideW       = ProdW + 1;

  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActPoint = 2'd1;
  localparam logic [1:0] ActSeg   = 2'd2;

  localparam logic [7:0] AddrCount = 8'd0;
endpackage
`default_nettype wire

>>> hw/rtl/polygon_point_segment_overlap.sv
// ----------------------------------------------------------------------------
// polygon_point_segment_overlap
// even-odd point in polygon and segment overlap test over a stored polygon
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: action, vertex_index, point_x, point_y, end_x, end_y
// m_axis    out  tdata: hit
// apb       in   vertex_count at address 0
//
// a load, an unused action or a query on an empty polygon goes from accept
// straight to the result; a point query makes one pass over the vertices, a
// segment query one pass for each endpoint and then an edge pass, and ends
// early on a hit; the pace is set by the single shared multiplier and the
// one ram port per store.
// reset clears control state and vertex_count; the stores are not cleared.
// the result waits in an output register; the block takes no request
// until its result is taken.
`default_nettype none
module polygon_point_segment_overlap (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // action[1:0] vertex_index[7:2] point_x[39:8] point_y[71:40]
  // end_x[103:72] end_y[135:104]
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // hit[0]
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int IW = ppso_pkg::IdxW;
  localparam int CW = ppso_pkg::CoordWidth;
  localparam int DW = ppso_pkg::DiffW;
  localparam int PW = ppso_pkg::ProdW;
  localparam int WW = ppso_pkg::WideW;
  localparam int NW = ppso_pkg::CntW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRdI  = 4'd1;  // address vertex i
  localparam logic [3:0] StRdJ  = 4'd2;  // capture i, address j
  localparam logic [3:0] StCapJ = 4'd3;  // capture j
  localparam logic [3:0] StM1   = 4'd4;
  localparam logic [3:0] StM2   = 4'd5;
  localparam logic [3:0] StM3   = 4'd6;
  localparam logic [3:0] StM4   = 4'd7;
  localparam logic [3:0] StM5   = 4'd8;
  localparam logic [3:0] StM6   = 4'd9;
  localparam logic [3:0] StEval = 4'd10;
  localparam logic [3:0] StOut  = 4'd11;

  localparam logic [1:0] PhP0  = 2'd0;  // start point
  localparam logic [1:0] PhP1  = 2'd1;  // end point
  localparam logic [1:0] PhEdg = 2'd2;  // edge pass

  logic [NW-1:0] count_q;
  logic [3:0]    st_q, st_d;
  logic [1:0]    ph_q;
  logic          seg_q, inside_q, hit_q, out_valid_q;
  logic [NW-1:0] i_q, n_q;
  logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [CW-1:0] xi_q, yi_q, xj_q, yj_q;
  logic signed [PW-1:0] p1_q;
  logic signed [WW-1:0] den_q, n1_q;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == ppso_pkg::AddrCount[2:0]) ? {{(32-NW){1'b0}}, count_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && paddr == ppso_pkg::AddrCount[2:0]) begin
      count_q <= pwdata[NW-1:0];
    end
  end

  wire [1:0]    in_act = s_axis_tdata[1:0];
  wire [5:0]    in_idx = s_axis_tdata[7:2];
  wire [CW-1:0] in_px  = s_axis_tdata[39:8];
  wire [CW-1:0] in_py  = s_axis_tdata[71:40];
  wire          take   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (st_q == StIdle) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, hit_q};

  // ram addressing
  logic [NW-1:0] j_idx;
  logic [NW-1:0] nxt;
  assign nxt = (i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1;
  always_comb begin
    if (ph_q == PhEdg) j_idx = nxt;
    else               j_idx = (i_q == '0) ? n_q - 1'b1 : i_q - 1'b1;
  end
  logic          we;
  logic [IW-1:0] addr;
  logic [CW-1:0] rx, ry;
  assign we   = take && in_act == ppso_pkg::ActLoad;
  assign addr = we ? in_idx[IW-1:0] : (st_q == StRdJ ? j_idx[IW-1:0] : i_q[IW-1:0]);
  ppso_ram #(.Width(CW), .Depth(ppso_pkg::MaxVertices)) u_ram_x (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(in_px), .rdata_o(rx));
  ppso_ram #(.Width(CW), .Depth(ppso_pkg::MaxVertices)) u_ram_y (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(in_py), .rdata_o(ry));

  // current query point
  logic signed [CW-1:0] qx, qy;
  assign qx = (ph_q == PhP1) ? ex_q : sx_q;
  assign qy = (ph_q == PhP1) ? ey_q : sy_q;

  function automatic logic signed [DW-1:0] df(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    df = DW'(a) - DW'(b);
  endfunction

  // shared multiplier operand select
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    if (ph_q != PhEdg) begin
      case (st_q)
        StM1:    begin ma = df(qx, xi_q);   mb = df(yj_q, yi_q); end
        StM2:    begin ma = df(xj_q, xi_q); mb = df(qy, yi_q);   end
        default: ;
      endcase
    end else begin
      // d1 = j - i, d2 = e - s, w = i - s
      case (st_q)
        StM1:    begin ma = df(xj_q, xi_q); mb = df(ey_q, sy_q); end
        StM2:    begin ma = df(yj_q, yi_q); mb = df(ex_q, sx_q); end
        StM3:    begin ma = df(yi_q, sy_q); mb = df(ex_q, sx_q); end
        StM4:    begin ma = df(xi_q, sx_q); mb = df(ey_q, sy_q); end
        StM5:    begin ma = df(yi_q, sy_q); mb = df(xj_q, xi_q); end
        StM6:    begin ma = df(xi_q, sx_q); mb = df(yj_q, yi_q); end
        default: ;
      endcase
    end
  end
  ppso_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(prod));

  function automatic logic unit_ratio(input logic signed [WW-1:0] n,
                                      input logic signed [WW-1:0] d);
    if (!d[WW-1]) unit_ratio = !n[WW-1] && !(d < n);
    else          unit_ratio = (n[WW-1] || n == '0) && !(n < d);
  endfunction

  logic signed [WW-1:0] diff_now;
  assign diff_now = WW'(p1_q) - WW'(prod);  // used at eval, edge pass n2
  logic straddle, cross_pt;
  assign straddle = (yi_q > qy) != (yj_q > qy);
  // p1_q = l, prod = r at eval of a point pass
  assign cross_pt = straddle && ((yj_q > yi_q) ? (p1_q < prod) : (prod < p1_q));

  logic ev_hit_pt;
  assign ev_hit_pt = inside_q ^ cross_pt;

  logic last;
  assign last = (i_q + 1'b1 == n_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      sx_q <= in_px;
      sy_q <= in_py;
      ex_q <= s_axis_tdata[103:72];
      ey_q <= s_axis_tdata[135:104];
    end
    if (st_q == StRdJ) begin
      xi_q <= rx;
      yi_q <= ry;
    end
    if (st_q == StCapJ) begin
      xj_q <= rx;
      yj_q <= ry;
    end
    case (st_q)
      StM2:    p1_q <= prod;
      StM3:    den_q <= WW'(p1_q) - WW'(prod);
      StM4:    p1_q <= prod;
      StM5:    n1_q <= WW'(p1_q) - WW'(prod);
      StM6:    p1_q <= prod;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      ph_q        <= PhP0;
      seg_q       <= 1'b0;
      inside_q    <= 1'b0;
      i_q         <= '0;
      n_q         <= '0;
    end else begin
      st_q <= st_d;
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: if (take) begin
          i_q      <= '0;
          ph_q     <= PhP0;
          inside_q <= 1'b0;
          seg_q    <= (in_act == ppso_pkg::ActSeg);
          n_q      <= (count_q > NW'(ppso_pkg::MaxVertices)) ?
                      NW'(ppso_pkg::MaxVertices) : count_q;
          hit_q    <= 1'b0;
        end
        StOut: out_valid_q <= 1'b1;
        StEval: begin
          if (ph_q != PhEdg) begin
            if (last) begin
              i_q <= '0;
              if (ev_hit_pt) begin
                hit_q <= 1'b1;
              end
              inside_q <= 1'b0;
              ph_q <= (seg_q && ph_q == PhP0) ? PhP1 : PhEdg;
            end else begin
              inside_q <= ev_hit_pt;
              i_q <= i_q + 1'b1;
            end
          end else begin
            if (den_q != '0 && unit_ratio(n1_q, den_q) && unit_ratio(diff_now, den_q))
              hit_q <= 1'b1;
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (take) begin
        if (in_act == ppso_pkg::ActPoint || in_act == ppso_pkg::ActSeg)
          st_d = (count_q == '0) ? StOut : StRdI;
        else
          st_d = StOut;
      end
      StRdI:  st_d = StRdJ;
      StRdJ:  st_d = StCapJ;
      StCapJ: st_d = StM1;
      StM1:   st_d = StM2;
      StM2:   st_d = (ph_q == PhEdg) ? StM3 : StEval;
      StM3:   st_d = StM4;
      StM4:   st_d = StM5;
      StM5:   st_d = StM6;
      StM6:   st_d = StEval;
      StEval: begin
        if (ph_q != PhEdg) begin
          if (!last)                       st_d = StRdI;
          else if (seg_q && !ev_hit_pt && !hit_q) st_d = StRdI;
          else                             st_d = StOut;
        end else if (hit_q || (den_q != '0 && unit_ratio(n1_q, den_q) &&
                     unit_ratio(diff_now, den_q)) || last) begin
          st_d = StOut;
        end else begin
          st_d = StRdI;
        end
      end
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic unused;
  assign unused = ^{pwdata[31:NW]};
endmodule
`default_nettype wire

>>> hw/rtl/ppso_ram.sv
// ----------------------------------------------------------------------------
// ppso_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ppso_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/ppso_mul.sv
// ----------------------------------------------------------------------------
// ppso_mul
// shared signed multiplier, one registered product per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ppso_mul (
  input  wire logic                              clk_i,
  input  wire logic signed [ppso_pkg::DiffW-1:0] a_i,
  input  wire logic signed [ppso_pkg::DiffW-1:0] b_i,
  output logic signed      [ppso_pkg::ProdW-1:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
`default_nettype wire

>>> tb/sv/tb_polygon_point_segment_overlap.sv
// ----------------------------------------------------------------------------
// tb_polygon_point_segment_overlap
// self-checking testbench for the polygon point / segment overlap block
// ----------------------------------------------------------------------------
// loads polygons through the request stream, sets vertex_count over apb,
// and predicts every hit with exact 128-bit arithmetic; results are checked
// in order against a queue of expected hits under several idle/stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_polygon_point_segment_overlap;

  localparam logic [1:0] ActNone = 2'd3;  // unused action code
  localparam int Unit = 65536;            // 1.0 in q16.16
  localparam int CycleLimit = 6000000;

  typedef logic signed [127:0] wide_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  polygon_point_segment_overlap u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // predictor state: the polygon as the block should hold it
  wide_t     poly_x [ppso_pkg::MaxVertices];
  wide_t     poly_y [ppso_pkg::MaxVertices];
  logic [6:0] poly_count = '0;
  bit        hit_queue [$];

  int idle_pct  = 0;   // sender gap chance per cycle, percent
  int stall_pct = 0;   // receiver stall chance per cycle, percent
  int hold_off  = 0;   // cycles left of a forced receiver hold-off
  int mismatches = 0;
  int cycles = 0;

  function automatic int used_count();
    return (poly_count > ppso_pkg::MaxVertices) ? ppso_pkg::MaxVertices : int'(poly_count);
  endfunction

  // even-odd ray crossing toward +x
  function automatic bit point_inside(wide_t px, wide_t py);
    int    n;
    int    j;
    bit    c;
    wide_t dy, lhs, rhs;
    n = used_count();
    c = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        dy  = poly_y[j] - poly_y[i];
        lhs = (px - poly_x[i]) * dy;
        rhs = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
        if (dy > 0 ? (lhs < rhs) : (rhs < lhs)) c = ~c;
      end
      j = i;
    end
    return c;
  endfunction

  // num / den within [0, 1], den nonzero
  function automatic bit in_unit(wide_t num, wide_t den);
    if (den >= 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  function automatic bit sides_meet(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                    wide_t cx, wide_t cy, wide_t ex, wide_t ey);
    wide_t d1x, d1y, d2x, d2y, wx, wy, den;
    d1x = bx - ax; d1y = by - ay;
    d2x = ex - cx; d2y = ey - cy;
    wx  = ax - cx; wy  = ay - cy;
    den = d1x * d2y - d1y * d2x;
    // parallel or degenerate: never a crossing
    if (den == 0) return 1'b0;
    return in_unit(wy * d2x - wx * d2y, den) && in_unit(wy * d1x - wx * d1y, den);
  endfunction

  function automatic bit segment_overlaps(wide_t sx, wide_t sy, wide_t ex, wide_t ey);
    int n;
    int k;
    n = used_count();
    if (point_inside(sx, sy) || point_inside(ex, ey)) return 1'b1;
    for (int i = 0; i < n; i++) begin
      k = (i + 1 == n) ? 0 : i + 1;
      if (sides_meet(poly_x[i], poly_y[i], poly_x[k], poly_y[k], sx, sy, ex, ey))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one accepted request to the polygon and returns its hit
  function automatic bit predict_hit(logic [1:0] act, logic [5:0] idx,
                                     logic signed [31:0] px, logic signed [31:0] py,
                                     logic signed [31:0] ex, logic signed [31:0] ey);
    wide_t wpx, wpy, wex, wey;
    wpx = px; wpy = py; wex = ex; wey = ey;
    case (act)
      ppso_pkg::ActLoad: begin
        poly_x[idx] = wpx;
        poly_y[idx] = wpy;
        return 1'b0;
      end
      ppso_pkg::ActPoint: return point_inside(wpx, wpy);
      ppso_pkg::ActSeg:   return segment_overlaps(wpx, wpy, wex, wey);
      default:  return 1'b0;
    endcase
  endfunction

  // request sender: gaps at idle_pct, holds valid until the block takes it
  task automatic send_req(logic [1:0] act, logic [5:0] idx,
                          logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] ex, logic signed [31:0] ey);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {ey, ex, py, px, idx, act};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    hit_queue.push_back(predict_hit(act, idx, px, py, ex, ey));
  endtask

  // waits for every expected hit, then lets the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (hit_queue.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // apb write of vertex_count, only issued with the block idle
  task automatic set_count(logic [31:0] value);
    drain();
    psel = 1'b1; pwrite = 1'b1; paddr = ppso_pkg::AddrCount[2:0]; pwdata = value;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    poly_count = value[6:0];
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // mostly near the polygon so both answers happen, sometimes anywhere
  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return int'($urandom_range(0, 2 * (1 << 20))) - (1 << 20);
  endfunction

  task automatic load_polygon(int n);
    for (int i = 0; i < n; i++)
      send_req(ppso_pkg::ActLoad, 6'(i), rand_coord(), rand_coord(), $urandom, $urandom);
  endtask

  // receiver: random stalls, or a forced hold-off while hold_off runs
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off      = hold_off - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker against the oldest expected hit
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0d", m_axis_tdata[0]);
      end else begin
        bit want;
        want = hit_queue.pop_front();
        if (m_axis_tdata[0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hit mismatch: expected %0d actual %0d", want, m_axis_tdata[0]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL polygon_point_segment_overlap");
      $finish;
    end
  end

  // every slot written first so no query can read an unwritten vertex;
  // with no vertices in use every query misses
  task automatic test_empty_polygon();
    for (int i = 0; i < ppso_pkg::MaxVertices; i++)
      send_req(ppso_pkg::ActLoad, 6'(i), rand_coord(), rand_coord(), rand_coord(),
               rand_coord());
    send_req(ppso_pkg::ActPoint, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_req(ppso_pkg::ActSeg, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
             32'h7fff_ffff);
  endtask

  // square of side 20 plus a repeated vertex to form a zero-length side
  task automatic test_square();
    send_req(ppso_pkg::ActLoad, 6'd0, -10 * Unit, -10 * Unit, 0, 0);
    send_req(ppso_pkg::ActLoad, 6'd1,  10 * Unit, -10 * Unit, 0, 0);
    send_req(ppso_pkg::ActLoad, 6'd2,  10 * Unit,  10 * Unit, 0, 0);
    send_req(ppso_pkg::ActLoad, 6'd3,  10 * Unit,  10 * Unit, 0, 0);
    send_req(ppso_pkg::ActLoad, 6'd4, -10 * Unit,  10 * Unit, 32'hffff_ffff, 32'hffff_ffff);
    set_count(32'd5);
    send_req(ppso_pkg::ActPoint, 6'd0, 0, 0, 0, 0);
    send_req(ppso_pkg::ActPoint, 6'd0, 20 * Unit, 0, 0, 0);
    send_req(ppso_pkg::ActPoint, 6'd0, -10 * Unit, 0, 0, 0);         // on the left side
    send_req(ppso_pkg::ActPoint, 6'd0, 10 * Unit, 10 * Unit, 0, 0);  // on a corner
    send_req(ppso_pkg::ActPoint, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    // segment through the square, both ends outside
    send_req(ppso_pkg::ActSeg, 6'd0, -20 * Unit, 0, 20 * Unit, 0);
    // segment clear of the square
    send_req(ppso_pkg::ActSeg, 6'd0, -20 * Unit, 20 * Unit, 20 * Unit, 30 * Unit);
    // segment along the top side: parallel, only the end touches
    send_req(ppso_pkg::ActSeg, 6'd0, 10 * Unit, 10 * Unit, 30 * Unit, 10 * Unit);
    // segment ending exactly on a side
    send_req(ppso_pkg::ActSeg, 6'd0, 10 * Unit, 0, 30 * Unit, 0);
    send_req(ppso_pkg::ActSeg, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000);
    send_req(ActNone, 6'd63, 0, 0, 0, 0);
    send_req(ActNone, 6'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // a count above the store size reads all 64 slots
    set_count(32'd127);
    send_req(ppso_pkg::ActPoint, 6'd0, 0, 0, 0, 0);
    send_req(ppso_pkg::ActSeg, 6'd0, -Unit, -Unit, Unit, Unit);
    set_count(32'd64);
    send_req(ppso_pkg::ActLoad, 6'd63, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send_req(ppso_pkg::ActSeg, 6'd0, 32'h8000_0000, 0, 32'h7fff_ffff, 0);
  endtask

  // a few blocks per mix: fresh polygon, count, then queries and noise
  task automatic test_random(int blocks);
    int n;
    int sel;
    logic signed [31:0] qx, qy;
    for (int b = 0; b < blocks; b++) begin
      sel = $urandom_range(29);
      if (sel == 0) n = 64;
      else if (sel == 1) n = $urandom_range(0, 2);
      else n = $urandom_range(3, 8);
      load_polygon(n);
      set_count((n == 64 && $urandom_range(1)) ? 32'(65 + $urandom_range(62)) : 32'(n));
      repeat (n == 64 ? 3 : 14) begin
        sel = $urandom_range(99);
        qx = rand_coord(); qy = rand_coord();
        if (sel < 8)
          send_req(ppso_pkg::ActLoad, 6'($urandom_range(n == 0 ? 63 : n - 1)), qx, qy,
                   $urandom, $urandom);
        else if (sel < 11)
          send_req(ActNone, 6'($urandom), $urandom, $urandom, $urandom, $urandom);
        else if (sel < 45)
          send_req(ppso_pkg::ActPoint, 6'($urandom), qx, qy, $urandom, $urandom);
        else
          send_req(ppso_pkg::ActSeg, 6'($urandom), qx, qy, rand_coord(), rand_coord());
      end
    end
  endtask

  // long receiver hold-off while requests keep coming, then a full pause
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_off = 3000;
    repeat (10) send_req(ppso_pkg::ActPoint, 6'd0, rand_coord(), rand_coord(), 0, 0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < ppso_pkg::MaxVertices; i++) begin
      poly_x[i] = '0;
      poly_y[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_polygon();
    test_square();
    idle_pct = 0;  stall_pct = 0;  test_random(21);
    idle_pct = 64; stall_pct = 0;  test_random(21);
    idle_pct = 0;  stall_pct = 64; test_random(21);
    test_backpressure();
    idle_pct = 11; stall_pct = 11; test_random(21);
    idle_pct = 0;  stall_pct = 0;
    set_count(32'd0);
    send_req(ppso_pkg::ActSeg, 6'd0, 0, 0, Unit, Unit);
    drain();
    repeat (50) @(negedge clk_i);

    if (mismatches == 0 && hit_queue.size() == 0)
      $display("PASS polygon_point_segment_overlap");
    else
      $display("FAIL polygon_point_segment_overlap");
    $finish;
  end
endmodule
